// File: sv/gdw_pkg.sv
// ----------------------------------------------------------------------------
// gdw_pkg
// Shared types and fixed constants of the Gaussian distance weight pipeline.
// ----------------------------------------------------------------------------
package gdw_pkg;

  localparam int MAX_DIST_W = 18;
  localparam int WEIGHT_W   = 18;
  localparam int THRESH_W   = 17;
  localparam int INV_W      = 16;
  localparam int IDX_W      = 10;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int EXP_W      = 20;
  localparam int M_W        = 39;
  localparam int M_DROP     = 7;
  localparam int RECIP_SHIFT = 37;
  localparam int SUM_W      = 35;
  localparam int FIRST_TERM = 2;
  localparam int LAST_TERM  = 15;
  localparam int SQUARINGS  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 2'd0,
    CFG_INV_SIGMA_SQ = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_reg_t;

  localparam logic                   ENABLE_RESET    = 1'b1;
  localparam logic [INV_W-1:0]       INV_RESET       = 16'd2560;
  localparam logic [THRESH_W-1:0]    THRESH_RESET    = 17'd32768;

  localparam logic [63:0]            BIG_PRODUCT     = 64'd409599804688;
  localparam logic [M_W-1:0]         HALF_DIVISOR    = 39'd195312;
  localparam logic [18:0]            DIVISOR         = 19'd390625;
  localparam logic [25:0]            DIVISOR_RECIP   = 26'd45035996;
  localparam logic [16:0]            WEIGHT_ONE      = 17'd65536;
  localparam logic signed [SUM_W-1:0] SUM_ONE        = 35'sd4294967296;
  localparam logic signed [SUM_W-1:0] SUM_MAX        = 35'sd4294967295;
  localparam logic [63:0]            SQ_ROUND        = 64'h0000_0000_8000_0000;

  localparam logic [31:0] TERM_RECIP [16] = '{
    32'd0,
    32'hFFFF_FFFF,
    32'((64'd1 << 32) / 64'd2),
    32'((64'd1 << 32) / 64'd3),
    32'((64'd1 << 32) / 64'd4),
    32'((64'd1 << 32) / 64'd5),
    32'((64'd1 << 32) / 64'd6),
    32'((64'd1 << 32) / 64'd7),
    32'((64'd1 << 32) / 64'd8),
    32'((64'd1 << 32) / 64'd9),
    32'((64'd1 << 32) / 64'd10),
    32'((64'd1 << 32) / 64'd11),
    32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd13),
    32'((64'd1 << 32) / 64'd14),
    32'((64'd1 << 32) / 64'd15)
  };

  typedef struct packed {
    logic                bypass;
    logic [WEIGHT_W-1:0] bypass_value;
    logic                exp_zero;
  } tag_t;

endpackage

// File: sv/gdw_neg_exp.sv
// ----------------------------------------------------------------------------
// gdw_neg_exp
// Pipelined exp(-E) in Q0.32: a Taylor series for exp(-E/16), one term per
// three stages, followed by four rounded squarings.
// ----------------------------------------------------------------------------
module gdw_neg_exp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [gdw_pkg::EXP_W-1:0]   in_e,
  input  gdw_pkg::tag_t               in_tag,
  output logic                        out_valid,
  output logic [31:0]                 out_s,
  output gdw_pkg::tag_t               out_tag
);

  localparam int FT  = gdw_pkg::FIRST_TERM;
  localparam int LT  = gdw_pkg::LAST_TERM;
  localparam int NSQ = gdw_pkg::SQUARINGS;
  localparam int SW  = gdw_pkg::SUM_W;
  localparam int EW  = gdw_pkg::EXP_W;

  logic                 vc [1:LT];
  logic [31:0]          tc [1:LT];
  logic [31:0]          yc [1:LT];
  logic signed [SW-1:0] dc [1:LT];
  gdw_pkg::tag_t        gc [1:LT];

  logic                 va [FT:LT];
  logic [31:0]          aa [FT:LT];
  logic [31:0]          ya [FT:LT];
  logic signed [SW-1:0] da [FT:LT];
  gdw_pkg::tag_t        ga [FT:LT];

  logic                 vb [FT:LT];
  logic [31:0]          qb [FT:LT];
  logic [31:0]          ab [FT:LT];
  logic [31:0]          yb [FT:LT];
  logic signed [SW-1:0] db [FT:LT];
  gdw_pkg::tag_t        gb [FT:LT];

  logic                 vq [0:NSQ];
  logic [31:0]          sq [0:NSQ];
  gdw_pkg::tag_t        gq [0:NSQ];

  logic [31:0]          y_in;
  logic [31:0]          s_clamp;

  assign y_in = 32'(in_e) << (32 - EW);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc[1] <= 1'b0;
    end else if (adv) begin
      vc[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tc[1] <= y_in;
      yc[1] <= y_in;
      dc[1] <= gdw_pkg::SUM_ONE - SW'(y_in);
      gc[1] <= in_tag;
    end
  end

  for (genvar k = FT; k <= LT; k++) begin : g_term
    localparam bit EVEN = (k % 2) == 0;
    logic [63:0] tprod;
    logic [63:0] rprod;
    logic [31:0] rem;
    logic [31:0] term;

    assign tprod = 64'(tc[k-1]) * 64'(yc[k-1]);
    assign rprod = 64'(aa[k]) * 64'(gdw_pkg::TERM_RECIP[k]);
    assign rem   = ab[k] - qb[k] * 32'(k);
    assign term  = qb[k] + 32'(rem >= 32'(k));

    always_ff @(posedge clk) begin
      if (rst) begin
        va[k] <= 1'b0;
        vb[k] <= 1'b0;
        vc[k] <= 1'b0;
      end else if (adv) begin
        va[k] <= vc[k-1];
        vb[k] <= va[k];
        vc[k] <= vb[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        aa[k] <= tprod[63:32];
        ya[k] <= yc[k-1];
        da[k] <= dc[k-1];
        ga[k] <= gc[k-1];

        qb[k] <= rprod[63:32];
        ab[k] <= aa[k];
        yb[k] <= ya[k];
        db[k] <= da[k];
        gb[k] <= ga[k];

        tc[k] <= term;
        yc[k] <= yb[k];
        dc[k] <= EVEN ? db[k] + SW'(term) : db[k] - SW'(term);
        gc[k] <= gb[k];
      end
    end
  end

  always_comb begin
    if (dc[LT] <= 0) begin
      s_clamp = '0;
    end else if (dc[LT] > gdw_pkg::SUM_MAX) begin
      s_clamp = '1;
    end else begin
      s_clamp = dc[LT][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else if (adv) begin
      vq[0] <= vc[LT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0] <= s_clamp;
      gq[0] <= gc[LT];
    end
  end

  for (genvar i = 1; i <= NSQ; i++) begin : g_square
    logic [63:0] sprod;

    assign sprod = 64'(sq[i-1]) * 64'(sq[i-1]) + gdw_pkg::SQ_ROUND;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else if (adv) begin
        vq[i] <= vq[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i] <= sprod[63:32];
        gq[i] <= gq[i-1];
      end
    end
  end

  assign out_valid = vq[NSQ];
  assign out_s     = sq[NSQ];
  assign out_tag   = gq[NSQ];

  a_series_positive: assert property (@(posedge clk) disable iff (rst)
    vc[LT] |-> dc[LT] > 0)
    else $error("Series sum is not positive at the last term.");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    vb[LT] |-> qb[LT] <= ab[LT])
    else $error("Term quotient estimate exceeds its dividend.");

  a_term_decay: assert property (@(posedge clk) disable iff (rst)
    vc[LT] |-> tc[LT] <= yc[LT])
    else $error("Last series term is larger than the first.");

endmodule

// File: sv/gaussian_distance_weight_top.sv
// ----------------------------------------------------------------------------
// gaussian_distance_weight_top
// An accepted input beat is registered through the square, scale, divide and neg_exp stages into the output queue.
// One input beat per cycle is accepted; a two-entry output queue lets the
// pipeline keep accepting while one result waits, and it stalls when full.
// Synchronous reset clears all valid bits and the output queue and loads the
// register defaults (enable 1, inv_sigma_sq 10.0, threshold 0.5).
// ----------------------------------------------------------------------------
module gaussian_distance_weight_top #(
  parameter int DISTANCE_BITS = 18
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gdw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [gdw_pkg::MAX_DIST_W-1:0]   distance,
  input  logic [gdw_pkg::IDX_W-1:0]        row_index,
  input  logic [gdw_pkg::IDX_W-1:0]        col_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gdw_pkg::WEIGHT_W-1:0]     weight
);

  localparam int DW     = (DISTANCE_BITS < gdw_pkg::MAX_DIST_W) ?
                          DISTANCE_BITS : gdw_pkg::MAX_DIST_W;
  localparam int SQ_W   = 2 * DW;
  localparam int PROD_W = SQ_W + gdw_pkg::INV_W;
  localparam int WW     = gdw_pkg::WEIGHT_W;
  localparam int MW     = gdw_pkg::M_W;
  localparam int EW     = gdw_pkg::EXP_W;

  logic                          enable;
  logic [gdw_pkg::INV_W-1:0]     inv_sigma_sq;
  logic [gdw_pkg::THRESH_W-1:0]  threshold;

  logic                          adv;
  logic                          v0, v1, v2, v3, v4, v5, v6;
  logic [DW-1:0]                 d0;
  logic [SQ_W-1:0]               sq1;
  logic [PROD_W-1:0]             p2;
  logic [MW-1:0]                 m3, m4, m5;
  logic [EW-1:0]                 qe4, qe5, e6;
  logic [MW-1:0]                 pr5;
  gdw_pkg::tag_t                 g0, g1, g2, g3, g4, g5, g6;

  logic [63:0]                   p_ext;
  logic                          big;
  logic [57:0]                   recip_prod;
  logic [MW-1:0]                 rem;

  logic                          vx;
  logic [31:0]                   sx;
  gdw_pkg::tag_t                 gx;
  logic [16:0]                   w_round;
  logic [16:0]                   kernel_w;
  logic [WW-1:0]                 result;

  logic [WW-1:0]                 queue [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic [1:0]                    count_next;
  logic                          push;
  logic                          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= gdw_pkg::ENABLE_RESET;
      inv_sigma_sq <= gdw_pkg::INV_RESET;
      threshold    <= gdw_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      case (gdw_pkg::cfg_reg_t'(cfg_index))
        gdw_pkg::CFG_ENABLE:       enable       <= cfg_data[0];
        gdw_pkg::CFG_INV_SIGMA_SQ: inv_sigma_sq <= cfg_data[gdw_pkg::INV_W-1:0];
        gdw_pkg::CFG_THRESHOLD:    threshold    <= cfg_data[gdw_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = (count != 2'd2);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign p_ext      = 64'(p2);
  assign big        = p_ext >= gdw_pkg::BIG_PRODUCT;
  assign recip_prod = 58'(m3[MW-1:gdw_pkg::M_DROP]) * 58'(gdw_pkg::DIVISOR_RECIP);
  assign rem        = m5 - pr5;

  always_ff @(posedge clk) begin
    if (adv) begin
      d0                <= distance[DW-1:0];
      g0.bypass         <= !enable || (row_index == col_index);
      g0.bypass_value   <= enable ? '0 : WW'(distance[DW-1:0]);
      g0.exp_zero       <= 1'b0;

      sq1 <= SQ_W'(d0) * SQ_W'(d0);
      g1  <= g0;

      p2  <= PROD_W'(sq1) * PROD_W'(inv_sigma_sq);
      g2  <= g1;

      m3              <= p_ext[MW-1:0] + gdw_pkg::HALF_DIVISOR;
      g3.bypass       <= g2.bypass || big;
      g3.bypass_value <= g2.bypass ? g2.bypass_value : '0;
      g3.exp_zero     <= 1'b0;

      qe4 <= recip_prod[gdw_pkg::RECIP_SHIFT +: EW];
      m4  <= m3;
      g4  <= g3;

      pr5 <= MW'(qe4) * MW'(gdw_pkg::DIVISOR);
      qe5 <= qe4;
      m5  <= m4;
      g5  <= g4;

      e6              <= qe5 + EW'(rem >= MW'(gdw_pkg::DIVISOR));
      g6.bypass       <= g5.bypass;
      g6.bypass_value <= g5.bypass_value;
      g6.exp_zero     <= (qe5 == '0) && (rem < MW'(gdw_pkg::DIVISOR));
    end
  end

  gdw_neg_exp u_neg_exp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v6),
    .in_e      (e6),
    .in_tag    (g6),
    .out_valid (vx),
    .out_s     (sx),
    .out_tag   (gx)
  );

  assign w_round  = 17'((33'(sx) + 33'h0_0000_8000) >> 16);
  assign kernel_w = gx.exp_zero ? gdw_pkg::WEIGHT_ONE : w_round;

  always_comb begin
    if (gx.bypass) begin
      result = gx.bypass_value;
    end else if (kernel_w >= threshold) begin
      result = WW'(kernel_w);
    end else begin
      result = '0;
    end
  end

  assign push = adv && vx;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

  assign count_next = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  assign out_valid = (count != 2'd0);
  assign weight    = queue[rd_ptr];

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (v5 && !g5.bypass) |-> (m5 - pr5) < (MW'(gdw_pkg::DIVISOR) << 1))
    else $error("Exponent quotient estimate is off by more than one.");

  a_kernel_range: assert property (@(posedge clk) disable iff (rst)
    (push && !gx.bypass) |-> result <= WW'(gdw_pkg::WEIGHT_ONE))
    else $error("Kernel weight above one.");

  a_queue_depth: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("Output queue overflow.");

endmodule
